[rtl/core/irenc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the IR air-conditioner remote frame encoder.
// No dependencies; used by irenc_front, irenc_back and the top level.
package irenc_pkg;

  // Segment timer width and configuration register width
  localparam int TimeWidth = 16;
  localparam int CfgWidth  = 16;
  localparam int NumRegs   = 7;
  localparam int CfgIdxW   = 3;
  localparam int PayloadW  = 40;

  // Frame layout: six bytes of eight bits each
  localparam int BitsPerFrame = 48;
  localparam int BitPosW      = 6;

  // Queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Input opcodes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CMD2   = 2'd1,
    OP_CMD3   = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_e;

  // Classified request kinds carried through the queue
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD2 = 2'd1,
    KIND_CMD3 = 2'd2
  } item_kind_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LEAD_MARK  = 3'd0,
    REG_LEAD_SPACE = 3'd1,
    REG_BIT_MARK   = 3'd2,
    REG_ZERO_SPACE = 3'd3,
    REG_ONE_SPACE  = 3'd4,
    REG_STOP_MARK  = 3'd5,
    REG_STOP_SPACE = 3'd6
  } cfg_reg_e;

  localparam logic [CfgWidth-1:0] CfgResetVal [NumRegs] = '{
    16'd4360, 16'd4460, 16'd478, 16'd600, 16'd1700, 16'd477, 16'd5277
  };

  // One queued request
  typedef struct packed {
    item_kind_e            kind;
    logic [PayloadW-1:0]   payload;
  } item_t;

  // One result
  typedef struct packed {
    logic mark;
    logic busy;
    logic rej;
    logic done;
  } result_t;

  // Register value to segment length: zero counts as one tick, saturate at timer max
  function automatic logic [TimeWidth-1:0] seg_len(input logic [CfgWidth-1:0] v);
    logic [31:0] ext;
    logic [31:0] tmax;
    tmax = (32'd1 << TimeWidth) - 32'd1;
    ext  = {{(32-CfgWidth){1'b0}}, v};
    if (ext > tmax) begin
      ext = tmax;
    end
    if (ext == 32'd0) begin
      ext = 32'd1;
    end
    return ext[TimeWidth-1:0];
  endfunction

endpackage

[rtl/core/irenc_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input requests, classifies the opcode and queues them.
// Depends on irenc_pkg.
module irenc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic [7:0]                    byte_a_i,
  input  logic [7:0]                    byte_b_i,
  input  logic [7:0]                    byte_c_i,
  input  logic [7:0]                    byte_q_i,
  input  logic [7:0]                    byte_y_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output irenc_pkg::item_t              q_item_o
);

  irenc_pkg::item_t                 item_in;
  irenc_pkg::item_t                 mem_q [irenc_pkg::QueueDepth];
  logic [irenc_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [irenc_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [irenc_pkg::QCntW-1:0]      count_q, count_d;
  logic                             push, pop;

  // Classify: unused opcode behaves as a tick
  always_comb begin
    case (irenc_pkg::opcode_e'(opcode_i))
      irenc_pkg::OP_CMD2: item_in.kind = irenc_pkg::KIND_CMD2;
      irenc_pkg::OP_CMD3: item_in.kind = irenc_pkg::KIND_CMD3;
      default:            item_in.kind = irenc_pkg::KIND_TICK;
    endcase
    item_in.payload = {byte_a_i, byte_b_i, byte_c_i, byte_q_i, byte_y_i};
  end

  assign in_ready_o = (count_q != irenc_pkg::QCntW'(irenc_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == irenc_pkg::QPtrW'(irenc_pkg::QueueDepth - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == irenc_pkg::QPtrW'(irenc_pkg::QueueDepth - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= irenc_pkg::QCntW'(irenc_pkg::QueueDepth))
    else $error("queue fill count above depth");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on push");

  a_count_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count did not shrink on pop");
`endif

endmodule

[rtl/core/irenc_back.sv]
`timescale 1ns / 1ps
// Back end: segment sequencer, timing registers and the result output register.
// Depends on irenc_pkg.
module irenc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [irenc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [irenc_pkg::CfgWidth-1:0]    cfg_wdata_i,
  input  logic                              q_valid_i,
  output logic                              q_ready_o,
  input  irenc_pkg::item_t                  q_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output irenc_pkg::result_t                result_o
);

  typedef enum logic [2:0] {
    SEG_IDLE       = 3'd0,
    SEG_LEAD_MARK  = 3'd1,
    SEG_LEAD_SPACE = 3'd2,
    SEG_BIT_MARK   = 3'd3,
    SEG_BIT_SPACE  = 3'd4,
    SEG_STOP_MARK  = 3'd5,
    SEG_STOP_SPACE = 3'd6
  } seg_e;

  logic [irenc_pkg::CfgWidth-1:0]   cfg_q [irenc_pkg::NumRegs];
  seg_e                             seg_q, seg_d;
  logic                             three_q, three_d;
  logic [1:0]                       frame_q, frame_d;
  logic [irenc_pkg::BitPosW-1:0]    bit_pos_q, bit_pos_d;
  logic [irenc_pkg::TimeWidth-1:0]  ticks_q, ticks_d, ticks_dec;
  logic [irenc_pkg::PayloadW-1:0]   payload_q, payload_d;
  logic                             out_valid_q, out_valid_d;
  irenc_pkg::result_t               result_q, res;
  logic                             take, busy, level, load;
  irenc_pkg::cfg_reg_e              len_sel;

  // Data bit of the present position: A ~A B ~B C ~C, third frame A ~A Q ~Q Y ~Y
  function automatic logic cur_bit(input logic [irenc_pkg::PayloadW-1:0] pl,
                                   input logic [1:0] frame,
                                   input logic [irenc_pkg::BitPosW-1:0] pos);
    logic [7:0] b;
    case (pos[5:4])
      2'd0:    b = pl[39:32];
      2'd1:    b = (frame == 2'd2) ? pl[15:8] : pl[31:24];
      default: b = (frame == 2'd2) ? pl[7:0]  : pl[23:16];
    endcase
    if (pos[3]) begin
      b = ~b;
    end
    return b[3'd7 - pos[2:0]];
  endfunction

  assign busy        = (seg_q != SEG_IDLE);
  assign level       = (seg_q == SEG_LEAD_MARK) || (seg_q == SEG_BIT_MARK) ||
                       (seg_q == SEG_STOP_MARK);
  assign q_ready_o   = !out_valid_q || out_ready_i;
  assign take        = q_valid_i && q_ready_o;
  assign ticks_dec   = ticks_q - 1'b1;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // Sequencer next state and result for one request
  always_comb begin
    seg_d     = seg_q;
    three_d   = three_q;
    frame_d   = frame_q;
    bit_pos_d = bit_pos_q;
    ticks_d   = ticks_q;
    payload_d = payload_q;
    res       = '0;
    load      = 1'b0;
    len_sel   = irenc_pkg::REG_LEAD_MARK;
    if (take) begin
      case (q_item_i.kind)
        irenc_pkg::KIND_CMD2, irenc_pkg::KIND_CMD3: begin
          if (busy) begin
            res.mark = level;
            res.busy = 1'b1;
            res.rej  = 1'b1;
          end else begin
            payload_d = q_item_i.payload;
            three_d   = (q_item_i.kind == irenc_pkg::KIND_CMD3);
            frame_d   = 2'd0;
            bit_pos_d = '0;
            seg_d     = SEG_LEAD_MARK;
            load      = 1'b1;
            len_sel   = irenc_pkg::REG_LEAD_MARK;
            res.mark  = 1'b1;
            res.busy  = 1'b1;
          end
        end
        default: begin
          if (busy) begin
            res.mark = level;
            res.busy = 1'b1;
            ticks_d  = ticks_dec;
            if (ticks_dec == '0) begin
              // Segment over: move on
              case (seg_q)
                SEG_LEAD_MARK: begin
                  seg_d   = SEG_LEAD_SPACE;
                  load    = 1'b1;
                  len_sel = irenc_pkg::REG_LEAD_SPACE;
                end
                SEG_LEAD_SPACE: begin
                  bit_pos_d = '0;
                  seg_d     = SEG_BIT_MARK;
                  load      = 1'b1;
                  len_sel   = irenc_pkg::REG_BIT_MARK;
                end
                SEG_BIT_MARK: begin
                  seg_d   = SEG_BIT_SPACE;
                  load    = 1'b1;
                  len_sel = cur_bit(payload_q, frame_q, bit_pos_q) ?
                            irenc_pkg::REG_ONE_SPACE : irenc_pkg::REG_ZERO_SPACE;
                end
                SEG_BIT_SPACE: begin
                  load = 1'b1;
                  if (bit_pos_q >= irenc_pkg::BitPosW'(irenc_pkg::BitsPerFrame - 1)) begin
                    seg_d   = SEG_STOP_MARK;
                    len_sel = irenc_pkg::REG_STOP_MARK;
                  end else begin
                    bit_pos_d = bit_pos_q + 1'b1;
                    seg_d     = SEG_BIT_MARK;
                    len_sel   = irenc_pkg::REG_BIT_MARK;
                  end
                end
                SEG_STOP_MARK: begin
                  seg_d   = SEG_STOP_SPACE;
                  load    = 1'b1;
                  len_sel = irenc_pkg::REG_STOP_SPACE;
                end
                default: begin
                  // End of a frame: next frame or end of sequence
                  if ((frame_q + 1'b1) < (three_q ? 2'd3 : 2'd2)) begin
                    frame_d   = frame_q + 1'b1;
                    bit_pos_d = '0;
                    seg_d     = SEG_LEAD_MARK;
                    load      = 1'b1;
                    len_sel   = irenc_pkg::REG_LEAD_MARK;
                  end else begin
                    seg_d     = SEG_IDLE;
                    frame_d   = 2'd0;
                    bit_pos_d = '0;
                    ticks_d   = '0;
                    res.done  = 1'b1;
                  end
                end
              endcase
            end
          end else begin
            seg_d = SEG_IDLE;
          end
        end
      endcase
    end
    if (load) begin
      ticks_d = irenc_pkg::seg_len(cfg_q[len_sel]);
    end
  end

  // Output register handshake
  always_comb begin
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state and timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= SEG_IDLE;
      three_q     <= 1'b0;
      frame_q     <= 2'd0;
      bit_pos_q   <= '0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < irenc_pkg::NumRegs; i++) begin
        cfg_q[i] <= irenc_pkg::CfgResetVal[i];
      end
    end else begin
      seg_q       <= seg_d;
      three_q     <= three_d;
      frame_q     <= frame_d;
      bit_pos_q   <= bit_pos_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i < irenc_pkg::CfgIdxW'(irenc_pkg::NumRegs))) begin
        cfg_q[cfg_idx_i] <= cfg_wdata_i;
      end
    end
  end

  // Payload and result registers
  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
    if (take) begin
      result_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_ticks_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_q != SEG_IDLE) |-> (ticks_q != '0))
    else $error("active segment with empty timer");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && res.done) |=> (seg_q == SEG_IDLE))
    else $error("sequence end did not return to idle");

  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.rej || result_q.mark || result_q.done)) |-> result_q.busy)
    else $error("result flags set without busy");

  a_bit_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_pos_q < irenc_pkg::BitPosW'(irenc_pkg::BitsPerFrame))
    else $error("bit position out of frame");
`endif

endmodule

[rtl/core/ir_ac_remote_frame_encoder.sv]
`timescale 1ns / 1ps
// Top level of the IR air-conditioner remote frame encoder.
// Depends on irenc_pkg, irenc_front and irenc_back.
//
//  channel   handshake                 payload
//  --------  ------------------------  -----------------------------------------
//  input     in_valid_i / in_ready_o   opcode_i, byte_a_i .. byte_y_i
//  result    out_valid_o / out_ready_i ir_mark_o, busy_res_o, rejected_o,
//                                      sequence_done_o
//  config    cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One request per clock sustained while out_ready_i is high; each result is
// registered and appears in the cycle after its request reaches the sequencer.
// A two-entry queue decouples the classifier from the sequencer, and the result
// register takes a new request when it is empty or its waiting result is taken.
// Reset loads the default timing registers and leaves the sequencer idle.
// With out_ready_i low, the result register and then the queue fill before
// in_ready_o drops.
module ir_ac_remote_frame_encoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [irenc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [irenc_pkg::CfgWidth-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        opcode_i,
  input  logic [7:0]                        byte_a_i,
  input  logic [7:0]                        byte_b_i,
  input  logic [7:0]                        byte_c_i,
  input  logic [7:0]                        byte_q_i,
  input  logic [7:0]                        byte_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              ir_mark_o,
  output logic                              busy_res_o,
  output logic                              rejected_o,
  output logic                              sequence_done_o
);

  logic                q_valid, q_ready;
  irenc_pkg::item_t    q_item;
  irenc_pkg::result_t  result;

  // Request classifier and queue
  irenc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .byte_a_i   (byte_a_i),
    .byte_b_i   (byte_b_i),
    .byte_c_i   (byte_c_i),
    .byte_q_i   (byte_q_i),
    .byte_y_i   (byte_y_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  // Segment sequencer and result register
  irenc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign ir_mark_o       = result.mark;
  assign busy_res_o      = result.busy;
  assign rejected_o      = result.rej;
  assign sequence_done_o = result.done;

endmodule
